/* design/i2da_pkg.sv */
package i2da_pkg;

  // Widths of the number and of its decimal image.
  localparam int unsigned ValueW    = 64;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned BcdW      = NumDigits * 4;
  localparam int unsigned BitCntW   = $clog2(ValueW);
  localparam int unsigned RemW      = $clog2(NumDigits + 1);

  // ASCII codes that the block emits.
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;

  // Input word: the raw bits and the reading mode.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              signed_mode;
  } in_t;

  // Result word: one character of the text.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } out_t;

  // Classified job passed from the front to the back.
  typedef struct packed {
    logic              negative;
    logic [ValueW-1:0] magnitude;
  } job_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BackIdle,
    BackConv,
    BackSkip,
    BackSign,
    BackEmit
  } back_state_e;

endpackage

/* design/i2da_front.sv */
module i2da_front
  import i2da_pkg::*;
(
  input  logic start_i,
  input  logic full_i,
  input  in_t  data_i,
  output logic push_o,
  output job_t job_o
);

  logic negative;

  // A word is taken when start is high and the queue has room.
  assign push_o = start_i & ~full_i;

  // Signed mode with the top bit set is negative; take the two's complement magnitude.
  assign negative = data_i.signed_mode & data_i.value[ValueW-1];

  assign job_o.negative  = negative;
  assign job_o.magnitude = negative ? (~data_i.value + {{(ValueW-1){1'b0}}, 1'b1})
                                    : data_i.value;

endmodule

/* design/i2da_queue.sv */
module i2da_queue
  import i2da_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output q_status_t status_o,
  output job_t      job_o
);

  job_t       entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  // Pointer and fill count update.
  always_comb begin
    wptr_d  = wptr_q ^ push_i;
    rptr_d  = rptr_q ^ pop_i;
    count_d = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= job_i;
    end
  end

  assign status_o.valid = (count_q != 2'd0);
  assign status_o.full  = (count_q == 2'd2);
  assign job_o          = entry_q[rptr_q];

endmodule

/* design/i2da_back.sv */
module i2da_back
  import i2da_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t status_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      strobe_o,
  output out_t      result_o
);

  back_state_e        state_q, state_d;
  logic [ValueW-1:0]  mag_q;
  logic [BcdW-1:0]    bcd_q;
  logic [BcdW-1:0]    bcd_adj;
  logic               neg_q;
  logic [BitCntW-1:0] bit_q;
  logic [RemW-1:0]    rem_q;
  logic [3:0]         top_digit;
  logic               lead_zero;

  assign top_digit = bcd_q[BcdW-1 -: 4];
  assign lead_zero = (top_digit == 4'd0) && (rem_q > {{(RemW-1){1'b0}}, 1'b1});

  // Double-dabble correction: every digit of five or more gets three added.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? (bcd_q[i*4 +: 4] + 4'd3)
                                                     : bcd_q[i*4 +: 4];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BackIdle: begin
        if (status_i.valid) begin
          state_d = BackConv;
        end
      end
      BackConv: begin
        if (bit_q == BitCntW'(ValueW - 1)) begin
          state_d = BackSkip;
        end
      end
      BackSkip: begin
        if (!lead_zero) begin
          state_d = neg_q ? BackSign : BackEmit;
        end
      end
      BackSign: begin
        state_d = BackEmit;
      end
      BackEmit: begin
        if (rem_q == {{(RemW-1){1'b0}}, 1'b1}) begin
          state_d = BackIdle;
        end
      end
      default: begin
        state_d = BackIdle;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    pop_o              = 1'b0;
    strobe_o           = 1'b0;
    result_o.char_code = CharZero + {4'd0, top_digit};
    result_o.last_char = 1'b0;
    case (state_q)
      BackIdle: begin
        pop_o = status_i.valid;
      end
      BackSign: begin
        strobe_o           = 1'b1;
        result_o.char_code = CharMinus;
      end
      BackEmit: begin
        strobe_o           = 1'b1;
        result_o.last_char = (rem_q == {{(RemW-1){1'b0}}, 1'b1});
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: load, shift one bit per cycle into the BCD word, then shift digits out.
  always_ff @(posedge clk_i) begin
    case (state_q)
      BackIdle: begin
        mag_q <= job_i.magnitude;
        neg_q <= job_i.negative;
        bcd_q <= '0;
        bit_q <= '0;
      end
      BackConv: begin
        bcd_q <= {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
        mag_q <= {mag_q[ValueW-2:0], 1'b0};
        bit_q <= bit_q + {{(BitCntW-1){1'b0}}, 1'b1};
        rem_q <= RemW'(NumDigits);
      end
      BackSkip: begin
        if (lead_zero) begin
          bcd_q <= {bcd_q[BcdW-5:0], 4'd0};
          rem_q <= rem_q - {{(RemW-1){1'b0}}, 1'b1};
        end
      end
      BackEmit: begin
        bcd_q <= {bcd_q[BcdW-5:0], 4'd0};
        rem_q <= rem_q - {{(RemW-1){1'b0}}, 1'b1};
      end
      default: begin
        bit_q <= bit_q;
      end
    endcase
  end

endmodule

/* design/int64_to_decimal_ascii_core.sv */
// Converts one 64-bit number to its decimal ASCII text.
// Input channel: data_i carries the value and the signed_mode flag; a word is
// taken at a rising edge where start is high and busy is low. busy is high
// only while the two-entry job queue between the front and back ends is full.
// Output channel: each character appears on result_o for one cycle with
// result_strobe_o high, most significant character first; last_char marks the
// final character. A negative signed value is preceded by '-'. The receiver
// cannot stall, so the back end runs freely once it has a job.
// Sequence: once the back end is idle it takes a queued job, runs bit-serial
// double-dabble over all 64 bits, then skips the leading zero digits, emits an
// optional sign character, and emits the digits one per strobe. Leading zeros
// and digits always add up to 20. The back end takes a new job only after the
// last character of the current number is out; the queue lets the next two
// words be taken while a conversion runs.
// Reset clears the queue and returns the back end to idle; no output is
// produced until a new word is taken.
module int64_to_decimal_ascii_core
  import i2da_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  data_i,
  output logic result_strobe_o,
  output out_t result_o
);

  logic      push;
  logic      pop;
  job_t      front_job;
  job_t      queue_job;
  q_status_t q_status;

  assign busy = q_status.full;

  // Front end: accepts and classifies a word.
  i2da_front u_front (
    .start_i (start),
    .full_i  (q_status.full),
    .data_i  (data_i),
    .push_o  (push),
    .job_o   (front_job)
  );

  // Short queue between the two ends.
  i2da_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (front_job),
    .pop_i    (pop),
    .status_o (q_status),
    .job_o    (queue_job)
  );

  // Back end: converts and emits characters.
  i2da_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (q_status),
    .job_i    (queue_job),
    .pop_o    (pop),
    .strobe_o (result_strobe_o),
    .result_o (result_o)
  );

endmodule

/* sim/int64_to_decimal_ascii_core_tb.sv */
`timescale 1ns / 1ps

module int64_to_decimal_ascii_core_tb;
  import i2da_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  data_i;
  logic result_strobe_o;
  out_t result_o;

  // Characters still owed by the block, oldest first.
  out_t pending_chars[$];
  int   error_count;
  bit   burst_mode;

  int64_to_decimal_ascii_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .data_i(data_i),
    .result_strobe_o(result_strobe_o),
    .result_o(result_o)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Works out the decimal text of one word and queues its characters.
  function automatic void predict_text(input in_t w);
    logic [ValueW-1:0] mag;
    logic              neg;
    logic [3:0]        digits[NumDigits];
    int                cnt;
    out_t              ch;
    neg = w.signed_mode && w.value[ValueW-1];
    mag = neg ? (~w.value + 64'd1) : w.value;
    cnt = 0;
    // Peel off digits, least significant first; zero still yields one digit.
    do begin
      digits[cnt] = 4'(mag % 64'd10);
      cnt++;
      mag = mag / 64'd10;
    end while (mag != 0);
    if (neg) begin
      ch.char_code = CharMinus;
      ch.last_char = 1'b0;
      pending_chars.push_back(ch);
    end
    for (int k = cnt - 1; k >= 0; k--) begin
      ch.char_code = CharZero + 8'(digits[k]);
      ch.last_char = (k == 0);
      pending_chars.push_back(ch);
    end
  endfunction

  // Offers one word after a random gap and waits until the block takes it.
  task automatic send_number(input logic [ValueW-1:0] value, input logic signed_mode);
    int   gap;
    in_t  w;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    w.value = value;
    w.signed_mode = signed_mode;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    data_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_text(w);
  endtask

  // Holds the sender off until every owed character has come out.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // A power of ten as a 64-bit value.
  function automatic logic [ValueW-1:0] pow10(input int e);
    logic [ValueW-1:0] p;
    p = 64'd1;
    for (int i = 0; i < e; i++) p = p * 64'd10;
    return p;
  endfunction

  // Draws a value of a random shape: full width, short, near a power of ten,
  // small negative, or truncated to a random width.
  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] v;
    int                w;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: ;
      1: v = 64'($urandom_range(0, 999));
      2: v = pow10($urandom_range(0, 19)) + 64'($signed($urandom_range(0, 2) - 1));
      3: v = -64'($urandom_range(1, 1000));
      default: begin
        w = $urandom_range(1, 63);
        v = v & ((64'd1 << w) - 64'd1);
      end
    endcase
    return v;
  endfunction

  // Edges of the range, zero, the most negative value and digit-count steps.
  task automatic test_directed_edges();
    send_number(64'd0, 1'b0);
    send_number(64'd0, 1'b1);
    send_number({64{1'b1}}, 1'b0);
    send_number({64{1'b1}}, 1'b1);
    send_number(64'h8000_0000_0000_0000, 1'b1);
    send_number(64'h8000_0000_0000_0000, 1'b0);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_number(64'h8000_0000_0000_0001, 1'b1);
    send_number(64'd1, 1'b1);
    send_number(64'd9, 1'b0);
    send_number(64'd10, 1'b1);
    send_number(-64'd10, 1'b1);
    send_number(-64'd10, 1'b0);
    send_number(64'd99, 1'b0);
    send_number(64'd100, 1'b0);
    send_number(pow10(19), 1'b0);
    send_number(pow10(19) - 64'd1, 1'b0);
    send_number(pow10(18), 1'b1);
    send_number(-pow10(18), 1'b1);
    send_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_number(64'h5555_5555_5555_5555, 1'b1);
  endtask

  // Random values of mixed shape, with bursts that leave no gap at all.
  task automatic test_random_values(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_number(pick_value(), 1'($urandom));
    end
    burst_mode = 1'b0;
  endtask

  // Words back to back so the job queue fills and busy pushes back.
  task automatic test_back_to_back();
    burst_mode = 1'b1;
    for (int i = 0; i < 12; i++) send_number({$urandom, $urandom}, 1'($urandom));
    burst_mode = 1'b0;
  endtask

  // A few words, then a full stop until the output side is empty.
  task automatic test_pause_until_drained();
    for (int i = 0; i < 4; i++) send_number(pick_value(), 1'($urandom));
    wait_drained();
    send_number(pick_value(), 1'b1);
  endtask

  // Compares each emitted character with the oldest owed one.
  always @(posedge clk_i) begin
    out_t exp_ch;
    if (rst_ni && result_strobe_o) begin
      if (pending_chars.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected char: code=%h last=%b", result_o.char_code,
                   result_o.last_char);
      end else begin
        exp_ch = pending_chars.pop_front();
        if (result_o.char_code !== exp_ch.char_code ||
            result_o.last_char !== exp_ch.last_char) begin
          error_count++;
          if (error_count <= 10)
            $display("char mismatch: expected code=%h last=%b, got code=%h last=%b",
                     exp_ch.char_code, exp_ch.last_char, result_o.char_code,
                     result_o.last_char);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    error_count = 0;
    burst_mode  = 1'b0;
    rst_ni = 1'b0;
    start  = 1'b0;
    data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_pause_until_drained();
    test_random_values(120);
    test_back_to_back();
    test_random_values(120);
    wait_drained();
    repeat (120) @(posedge clk_i);
    if (error_count == 0) begin
      $display("int64_to_decimal_ascii_core_tb: done, clean");
    end else begin
      $display("int64_to_decimal_ascii_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4000000;
    $display("int64_to_decimal_ascii_core_tb: done, errors");
    $finish;
  end

endmodule

/* int64_to_decimal_ascii_core.f */
design/i2da_pkg.sv
design/i2da_front.sv
design/i2da_queue.sv
design/i2da_back.sv
design/int64_to_decimal_ascii_core.sv
sim/int64_to_decimal_ascii_core_tb.sv
